// ----- rtl/core/dust_particle_step_core_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the dust particle step core
// Concurrent assertion helpers clocked on clk_i, used by the core's queue.
// ----------------------------------------------------------------------------
`ifndef DUST_PARTICLE_STEP_CORE_ASSERT_SVH
`define DUST_PARTICLE_STEP_CORE_ASSERT_SVH

// Checked only while the block is out of reset.
`define DPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define DPS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- rtl/core/dps_pkg.sv -----
// ----------------------------------------------------------------------------
// Dust particle step package
// Payload types, configuration types and fixed constants of the core.
// ----------------------------------------------------------------------------
package dps_pkg;

  localparam int DIV_QW     = 16;  // quotient bits of the alpha dividers
  localparam int SQRT_W     = 32;  // result bits of the radius square root
  localparam int ENV_FAC_W  = 36;
  localparam int ENV_DEN_W  = 34;
  localparam int CFG_IDX_W  = 2;

  localparam logic [15:0] ALPHA_ONE = 16'h8000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_ALPHA = 2'd0,
    CFG_FADE_INNER = 2'd1,
    CFG_FADE_OUTER = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic [31:0]        age;
    logic [31:0]        life_span;
    logic [31:0]        step_time;
  } dps_in_t;

  typedef struct packed {
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_pos_z;
    logic [31:0]        new_age;
    logic [15:0]        opacity;
    logic               alive;
  } dps_out_t;

  typedef struct packed {
    logic [15:0] base_alpha;
    logic [31:0] fade_inner_radius;
    logic [31:0] fade_outer_radius;
  } dps_cfg_t;

  // Classified particle handed from the front to the back.
  typedef struct packed {
    logic signed [31:0]    pos_x;
    logic signed [31:0]    pos_y;
    logic signed [31:0]    pos_z;
    logic signed [31:0]    vel_x;
    logic signed [31:0]    vel_y;
    logic signed [31:0]    vel_z;
    logic [31:0]           step;
    logic [31:0]           t;
    logic                  dead;
    logic [ENV_FAC_W-1:0]  env_fac;
    logic [ENV_DEN_W-1:0]  env_den;
  } dps_cmd_t;

endpackage

// ----- rtl/core/dust_particle_step_core.sv -----
// ----------------------------------------------------------------------------
// Dust particle step core
// Advances one particle per transfer: age, move, alpha envelope, radial fade.
// ----------------------------------------------------------------------------
// The core takes one particle per clock cycle while in_stall_o is low and
// returns one result per particle, in order. A particle passes the front
// register, then the queue, then the back pipeline, whose depth is set by the
// 32-stage square root of the radial distance and the two 16-stage alpha
// dividers. While a result is stalled the back pipeline holds and the queue
// of QUEUE_DEPTH entries keeps taking particles until it fills. Configuration
// writes are held in registers that the back pipeline reads.
module dust_particle_step_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  dps_pkg::dps_in_t                  in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output dps_pkg::dps_out_t                 out_data_o,
  input  logic                              cfg_we_i,
  input  logic [dps_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [31:0]                       cfg_wdata_i
);

  dps_pkg::dps_cfg_t cfg_q;
  dps_pkg::dps_cmd_t push_data, q_data;
  logic push, full, q_valid, pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base_alpha        <= dps_pkg::ALPHA_ONE;
      cfg_q.fade_inner_radius <= '0;
      cfg_q.fade_outer_radius <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dps_pkg::CFG_BASE_ALPHA: cfg_q.base_alpha        <= cfg_wdata_i[15:0];
        dps_pkg::CFG_FADE_INNER: cfg_q.fade_inner_radius <= cfg_wdata_i;
        dps_pkg::CFG_FADE_OUTER: cfg_q.fade_outer_radius <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  dps_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .full_i      (full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  dps_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .data_o      (q_data)
  );

  dps_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_data),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- rtl/core/dps_front.sv -----
// ----------------------------------------------------------------------------
// Dust particle step front
// Takes particles in, advances the age and classifies life and envelope.
// ----------------------------------------------------------------------------
module dps_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  dps_pkg::dps_in_t in_data_i,
  input  logic             full_i,
  output logic             push_o,
  output dps_pkg::dps_cmd_t push_data_o
);

  logic             f_vld_q;
  dps_pkg::dps_in_t f_item_q;
  logic [31:0]      f_t_q;
  logic [32:0]      t_sum;
  logic             accept;

  logic [35:0] t10;
  logic [33:0] l3;
  logic [31:0] diff;
  logic [32:0] diff2;
  logic        ramp_done;
  logic        in_fade;

  assign in_stall_o = f_vld_q && full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = f_vld_q && !full_i;

  assign t_sum = {1'b0, in_data_i.age} + {1'b0, in_data_i.step_time};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_vld_q <= 1'b0;
    end else if (accept) begin
      f_vld_q <= 1'b1;
    end else if (push_o) begin
      f_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      f_item_q <= in_data_i;
      f_t_q    <= t_sum[32] ? 32'hFFFF_FFFF : t_sum[31:0];
    end
  end

  // Envelope: ramp up below 30% of life, fade over the last half.
  always_comb begin
    t10       = {f_t_q, 3'b000} + {3'b000, f_t_q, 1'b0};
    l3        = {1'b0, f_item_q.life_span, 1'b0} + {2'b00, f_item_q.life_span};
    diff      = f_item_q.life_span - f_t_q;
    diff2     = {diff, 1'b0};
    ramp_done = t10 >= {2'b00, l3};
    in_fade   = diff2 < {1'b0, f_item_q.life_span};

    push_data_o.pos_x = f_item_q.pos_x;
    push_data_o.pos_y = f_item_q.pos_y;
    push_data_o.pos_z = f_item_q.pos_z;
    push_data_o.vel_x = f_item_q.vel_x;
    push_data_o.vel_y = f_item_q.vel_y;
    push_data_o.vel_z = f_item_q.vel_z;
    push_data_o.step  = f_item_q.step_time;
    push_data_o.t     = f_t_q;
    push_data_o.dead  = f_t_q > f_item_q.life_span;
    if (!ramp_done) begin
      push_data_o.env_fac = t10;
      push_data_o.env_den = l3;
    end else if (in_fade) begin
      push_data_o.env_fac = {3'b000, diff2};
      push_data_o.env_den = {2'b00, f_item_q.life_span};
    end else begin
      // Full envelope: divide the base alpha by one.
      push_data_o.env_fac = 36'd1;
      push_data_o.env_den = 34'd1;
    end
  end

endmodule

// ----- rtl/core/dps_queue.sv -----
// ----------------------------------------------------------------------------
// Dust particle step queue
// Short register queue between the front and the back.
// ----------------------------------------------------------------------------
module dps_queue #(
  parameter int DEPTH = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  dps_pkg::dps_cmd_t push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output dps_pkg::dps_cmd_t data_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  dps_pkg::dps_cmd_t mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]  cnt_q;

  assign full_o  = cnt_q == CNT_W'(DEPTH);
  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

`include "dust_particle_step_core_assert.svh"

  `DPS_ASSERT_ALWAYS(a_cnt_range, cnt_q <= CNT_W'(DEPTH), "queue count above depth")
  `DPS_ASSERT(a_no_push_full, push_i |-> !full_o, "push into a full queue")
  `DPS_ASSERT(a_no_pop_empty, pop_i |-> valid_o, "pop from an empty queue")
  `DPS_ASSERT(a_cnt_inc, (push_i && !pop_i) |=> (cnt_q == CNT_W'($past(cnt_q) + 1'b1)), "count did not grow")

endmodule

// ----- rtl/core/dps_div.sv -----
// ----------------------------------------------------------------------------
// Dust particle step divider
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module dps_div #(
  parameter int NUM_W = 52,
  parameter int DEN_W = 34,
  parameter int Q_W   = 16
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [Q_W-1:0]   quo_o
);

  // The quotient must fit in Q_W bits: num < den * 2^Q_W.
  localparam int RW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

  logic [RW-1:0]    rem_q [Q_W-1];
  logic [DEN_W-1:0] den_q [Q_W-1];
  logic [Q_W-1:0]   quo_q [Q_W];

  for (genvar s = 0; s < Q_W; s++) begin : g_stage
    logic [RW-1:0]    rem_in, rem_d, sh;
    logic [DEN_W-1:0] den_in;
    logic [Q_W-1:0]   quo_in, quo_d;
    logic             ge;

    if (s == 0) begin : g_first
      assign rem_in = RW'(num_i);
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign den_in = den_q[s-1];
      assign quo_in = quo_q[s-1];
    end

    always_comb begin
      sh    = RW'(den_in) << (Q_W - 1 - s);
      ge    = rem_in >= sh;
      rem_d = ge ? rem_in - sh : rem_in;
      quo_d = quo_in;
      quo_d[Q_W-1-s] = ge;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[s] <= quo_d;
      end
    end

    if (s < Q_W - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[s] <= rem_d;
          den_q[s] <= den_in;
        end
      end
    end
  end

  assign quo_o = quo_q[Q_W-1];

endmodule

// ----- rtl/core/dps_isqrt.sv -----
// ----------------------------------------------------------------------------
// Dust particle step square root
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module dps_isqrt #(
  parameter int RES_W = 32
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [2*RES_W-1:0] val_i,
  output logic [RES_W-1:0]   root_o
);

  localparam int IN_W = 2 * RES_W;

  logic [IN_W-1:0]  rem_q  [RES_W-1];
  logic [RES_W-1:0] root_q [RES_W];

  for (genvar s = 0; s < RES_W; s++) begin : g_stage
    localparam int B = RES_W - 1 - s;
    logic [IN_W-1:0]  rem_in, rem_d, trial;
    logic [RES_W-1:0] root_in, root_d;
    logic             ge;

    if (s == 0) begin : g_first
      assign rem_in  = val_i;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
    end

    // (r + 2^b)^2 - r^2 = r * 2^(b+1) + 2^(2b)
    always_comb begin
      trial  = (IN_W'(root_in) << (B + 1)) | (IN_W'(1) << (2 * B));
      ge     = rem_in >= trial;
      rem_d  = ge ? rem_in - trial : rem_in;
      root_d = root_in;
      root_d[B] = ge;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        root_q[s] <= root_d;
      end
    end

    if (s < RES_W - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[s] <= rem_d;
        end
      end
    end
  end

  assign root_o = root_q[RES_W-1];

endmodule

// ----- rtl/core/dps_back.sv -----
// ----------------------------------------------------------------------------
// Dust particle step back
// Arithmetic pipeline: move, envelope divide, radial fade and output register.
// ----------------------------------------------------------------------------
module dps_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dps_pkg::dps_cfg_t  cfg_i,
  input  logic               cmd_valid_i,
  input  dps_pkg::dps_cmd_t  cmd_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output dps_pkg::dps_out_t  out_data_o
);

  localparam int QW     = dps_pkg::DIV_QW;
  localparam int SW     = dps_pkg::SQRT_W;
  localparam int ENV_N  = 16 + dps_pkg::ENV_FAC_W;
  // Entry k of the line is registered after the a_ stage and entries 0 to k-1.
  localparam int FLAG_WR = 2;
  localparam int ENV_WR  = QW;
  localparam int NUM_WR  = SW + 3;
  localparam int SAT_WR  = NUM_WR + 2;
  localparam int LAST    = NUM_WR + 1 + QW;
  localparam int LINE_N  = LAST + 1;

  typedef struct packed {
    logic signed [31:0] np_x;
    logic signed [31:0] np_y;
    logic signed [31:0] np_z;
    logic [31:0]        t;
    logic               dead;
    logic               kill;
    logic               fade;
    logic [15:0]        alpha;
    logic [31:0]        num;
    logic               sat;
  } bk_line_t;

  function automatic logic signed [31:0] sat_move(logic signed [31:0] pos,
                                                  logic signed [64:0] prod);
    logic signed [65:0] sum;
    sum = 66'(pos) + 66'(prod >>> 16);
    if (sum[65:31] == '0 || sum[65:31] == '1) begin
      return sum[31:0];
    end
    return sum[65] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
  endfunction

  logic adv;
  logic a_vld_q;
  logic [LINE_N-1:0] vld_q;
  logic out_vld_q;

  logic signed [64:0] a_prod_x_q, a_prod_y_q, a_prod_z_q;
  logic signed [31:0] a_pos_x_q, a_pos_y_q, a_pos_z_q;
  logic [31:0]        a_t_q;
  logic               a_dead_q;
  logic [ENV_N-1:0]   env_num_q;
  logic [dps_pkg::ENV_DEN_W-1:0] env_den_q;
  logic [QW-1:0]      env_q;

  bk_line_t line_q [LINE_N];
  bk_line_t line_d [LINE_N];

  logic [63:0] sq_x_q, sq_z_q, d2_q, d2;
  logic [63:0] rin_sq_q, rout_sq_q;
  logic        fade_en, in_rad, out_rad;
  logic [SW-1:0] root;
  logic [31:0]   rad_num;
  logic [47:0]   n_q, n_d;
  logic [31:0]   d_q, d_d;
  logic [QW-1:0] fq;
  logic          sat;
  dps_pkg::dps_out_t out_q, out_d;
  bk_line_t      fl, ol;

  // The whole back advances together; it holds while a result waits.
  assign adv         = !out_vld_q || !out_stall_i;
  assign pop_o       = adv && cmd_valid_i;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q   <= 1'b0;
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      a_vld_q   <= cmd_valid_i;
      vld_q     <= {vld_q[LINE_N-2:0], a_vld_q};
      out_vld_q <= vld_q[LAST];
    end
  end

  dps_div #(
    .NUM_W (ENV_N),
    .DEN_W (dps_pkg::ENV_DEN_W),
    .Q_W   (QW)
  ) u_env_div (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (env_num_q),
    .den_i (env_den_q),
    .quo_o (env_q)
  );

  dps_isqrt #(
    .RES_W (SW)
  ) u_isqrt (
    .clk_i  (clk_i),
    .en_i   (adv),
    .val_i  (d2_q),
    .root_o (root)
  );

  dps_div #(
    .NUM_W (48),
    .DEN_W (32),
    .Q_W   (QW)
  ) u_fade_div (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (n_q),
    .den_i (d_q),
    .quo_o (fq)
  );

  always_comb begin
    fade_en = cfg_i.fade_inner_radius != '0;
    d2      = sq_x_q + sq_z_q;
    in_rad  = d2 < rin_sq_q;
    out_rad = d2 > rout_sq_q;
    rad_num = (cfg_i.fade_outer_radius >= 32'(root)) ?
              cfg_i.fade_outer_radius - 32'(root) : '0;
    sat     = n_q >= ((48'(d_q) << 15) + 48'(d_q));

    line_d[0]      = '0;
    line_d[0].np_x = a_dead_q ? a_pos_x_q : sat_move(a_pos_x_q, a_prod_x_q);
    line_d[0].np_y = a_dead_q ? a_pos_y_q : sat_move(a_pos_y_q, a_prod_y_q);
    line_d[0].np_z = a_dead_q ? a_pos_z_q : sat_move(a_pos_z_q, a_prod_z_q);
    line_d[0].t    = a_t_q;
    line_d[0].dead = a_dead_q;
    for (int k = 1; k < LINE_N; k++) begin
      line_d[k] = line_q[k-1];
    end
    line_d[FLAG_WR].kill = fade_en && in_rad && out_rad;
    line_d[FLAG_WR].fade = fade_en && in_rad && !out_rad;
    line_d[ENV_WR].alpha = env_q;
    line_d[NUM_WR].num   = rad_num;
    line_d[SAT_WR].sat   = sat;
  end

  // Outside the fade the alpha goes through the divider over one.
  always_comb begin
    fl = line_q[NUM_WR];
    if (!fl.fade) begin
      n_d = 48'(fl.alpha);
      d_d = 32'd1;
    end else if (cfg_i.fade_outer_radius <= cfg_i.fade_inner_radius) begin
      n_d = '0;
      d_d = 32'd1;
    end else begin
      n_d = 48'(fl.alpha) * 48'(fl.num);
      d_d = cfg_i.fade_outer_radius - cfg_i.fade_inner_radius;
    end
  end

  always_comb begin
    ol = line_q[LAST];
    out_d.new_pos_x = ol.np_x;
    out_d.new_pos_y = ol.np_y;
    out_d.new_pos_z = ol.np_z;
    out_d.new_age   = ol.t;
    if (ol.dead || ol.kill) begin
      out_d.opacity = '0;
      out_d.alive   = 1'b0;
    end else begin
      out_d.opacity = ol.sat ? dps_pkg::ALPHA_ONE : 16'(fq);
      out_d.alive   = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    rin_sq_q  <= 64'(cfg_i.fade_inner_radius) * 64'(cfg_i.fade_inner_radius);
    rout_sq_q <= 64'(cfg_i.fade_outer_radius) * 64'(cfg_i.fade_outer_radius);
    if (adv) begin
      a_prod_x_q <= 65'(cmd_i.vel_x) * 65'($signed({1'b0, cmd_i.step}));
      a_prod_y_q <= 65'(cmd_i.vel_y) * 65'($signed({1'b0, cmd_i.step}));
      a_prod_z_q <= 65'(cmd_i.vel_z) * 65'($signed({1'b0, cmd_i.step}));
      a_pos_x_q  <= cmd_i.pos_x;
      a_pos_y_q  <= cmd_i.pos_y;
      a_pos_z_q  <= cmd_i.pos_z;
      a_t_q      <= cmd_i.t;
      a_dead_q   <= cmd_i.dead;
      env_num_q  <= ENV_N'(cfg_i.base_alpha) * ENV_N'(cmd_i.env_fac);
      env_den_q  <= cmd_i.env_den;
      line_q     <= line_d;
      sq_x_q     <= 64'(line_q[0].np_x) * 64'(line_q[0].np_x);
      sq_z_q     <= 64'(line_q[0].np_z) * 64'(line_q[0].np_z);
      d2_q       <= d2;
      n_q        <= n_d;
      d_q        <= d_d;
      out_q      <= out_d;
    end
  end

endmodule
